// ===== design/vwc_pkg.sv =====
package vwc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned InitCw   = 8;   // code width at stream start
  localparam int unsigned FirstNew = 256; // first dictionary code past the literals
  localparam int unsigned MaxOut   = 4;   // output bytes kept per input byte

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;       // clear one table slot
    logic init;      // return stream state to start values
    logic latch;     // take the input request, load hash slot
    logic first;     // start string with the byte
    logic set_hit;   // string extends to the matched code
    logic probe_nxt; // step to the next slot
    logic append;    // pack the prefix code
    logic produce;   // emit one whole packed byte
    logic flush;     // emit the zero padded tail byte
    logic insert;    // add entry, restart string with the byte
    logic fin;       // release the held byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic pv;
    logic last;
    logic hit;
    logic empty;
    logic ge8;
    logic nz;
    logic can_put;
    logic hold_v;
    logic out_free;
  } sts_t;

endpackage

// ===== design/lzw_compressor_variable_width_unit.sv =====
// Streaming dictionary compressor with growing code width.
// Input channel (in_valid_i/in_ready_o/in_req_i): one request per
// uncompressed byte; in_last marks the end of a stream.
// Output channel (out_valid_o/out_ready_i/out_req_o): packed code bytes,
// MSB first; out_last flags the final byte of a stream, zero padded if needed.
// A byte that extends the string passes through read, compare, check and
// finish; a miss adds a read and compare per extra probe of the hash table,
// then packing, draining and insert, and waits on the receiver to emit bytes.
// The unit takes no new byte until it is through with the last one.
// At reset, and again after every stream's last byte, a clearing pass
// writes all 2^clog2(DICT_SIZE) table slots, one per cycle, during which
// in_ready_o is low. Each stream starts with a fresh dictionary.
// A stalled receiver backs up into the held byte and the output register;
// the unit then waits and takes no new request until the byte moves.
module lzw_compressor_variable_width_unit import vwc_pkg::*; #(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: probe, pack, insert, flush
  vwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hash table, string state, bit packer, output register
  vwc_dp #(
    .DICT_SIZE (DICT_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ===== design/vwc_dp.sv =====
module vwc_dp import vwc_pkg::*; #(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  output sts_t     sts_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  localparam int unsigned CW    = $clog2(DICT_SIZE);
  localparam int unsigned DEPTH = 2 ** CW;
  localparam int unsigned PW    = CW + ByteW;
  localparam int unsigned CNTW  = $clog2(PW + 1);

  typedef struct packed {
    logic          v;
    logic [CW-1:0] prefix;
    logic [7:0]    data;
    logic [CW-1:0] code;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rd_q, wd;
  logic we;
  logic [CW-1:0] wa;

  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [CW-1:0]   prefix_q, prefix_d;
  logic            pv_q, pv_d;
  logic [CW:0]     nc_q, nc_d, nc_inc;
  logic [4:0]      cw_q, cw_d;
  logic [PW-1:0]   pend_q, pend_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CW-1:0]   slot_q, slot_d;
  logic [CW-1:0]   clr_q, clr_d;
  logic [7:0]      hold_q, hold_d, new_b;
  logic            hold_v_q, hold_v_d;
  logic [2:0]      nout_q, nout_d;
  logic            out_v_q, out_v_d;
  out_req_t        out_q, out_d;
  logic            out_free, room, put;

  assign out_free = !out_v_q || out_ready_i;
  assign room     = (nout_q < 3'(MaxOut));
  assign nc_inc   = nc_q + 1'b1;
  assign put      = cmd_i.produce || cmd_i.flush;
  assign new_b    = cmd_i.flush ? 8'(pend_q << (CNTW'(ByteW) - cnt_q))
                                : 8'(pend_q >> (cnt_q - CNTW'(ByteW)));

  assign we = cmd_i.clr || (cmd_i.insert && (nc_q < (CW+1)'(DICT_SIZE)));
  assign wa = cmd_i.clr ? clr_q : slot_q;
  always_comb begin
    wd = '0;
    if (!cmd_i.clr) begin
      wd = '{v: 1'b1, prefix: prefix_q, data: byte_q, code: nc_q[CW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[slot_q];
  end

  always_comb begin
    byte_d   = byte_q;
    last_d   = last_q;
    prefix_d = prefix_q;
    pv_d     = pv_q;
    nc_d     = nc_q;
    cw_d     = cw_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    slot_d   = slot_q;
    clr_d    = clr_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    nout_d   = nout_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (cmd_i.clr) begin
      clr_d = clr_q + 1'b1;
    end
    if (cmd_i.init) begin
      prefix_d = '0;
      pv_d     = 1'b0;
      nc_d     = (CW+1)'(FirstNew);
      cw_d     = 5'(InitCw);
      cnt_d    = '0;
      clr_d    = '0;
    end
    if (cmd_i.latch) begin
      byte_d   = in_req_i.in_byte;
      last_d   = in_req_i.in_last;
      slot_d   = {in_req_i.in_byte, (CW-8)'(0)} ^ prefix_q;
      hold_v_d = 1'b0;
      nout_d   = '0;
    end
    if (cmd_i.first) begin
      prefix_d = CW'(in_req_i.in_byte);
      pv_d     = 1'b1;
    end
    if (cmd_i.set_hit) begin
      prefix_d = rd_q.code;
    end
    if (cmd_i.probe_nxt) begin
      slot_d = slot_q + 1'b1;
    end
    if (cmd_i.append) begin
      pend_d = PW'((pend_q << cw_q) | PW'(prefix_q));
      cnt_d  = cnt_q + CNTW'(cw_q);
    end
    if (put) begin
      cnt_d = cmd_i.flush ? '0 : cnt_q - CNTW'(ByteW);
      if (room) begin
        if (hold_v_q) begin
          out_d   = '{out_byte: hold_q, out_last: 1'b0};
          out_v_d = 1'b1;
        end
        hold_d   = new_b;
        hold_v_d = 1'b1;
        nout_d   = nout_q + 1'b1;
      end
    end
    if (cmd_i.insert) begin
      prefix_d = CW'(byte_q);
      if (nc_q < (CW+1)'(DICT_SIZE)) begin
        nc_d = nc_inc;
        if ({1'b0, nc_inc} > ((CW+2)'(1) << cw_q)) begin
          cw_d = cw_q + 1'b1;
        end
      end
    end
    if (cmd_i.fin && hold_v_q) begin
      out_d    = '{out_byte: hold_q, out_last: last_q};
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      pv_q     <= 1'b0;
      nc_q     <= (CW+1)'(FirstNew);
      cw_q     <= 5'(InitCw);
      cnt_q    <= '0;
      clr_q    <= '0;
      hold_v_q <= 1'b0;
      nout_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
      pv_q     <= pv_d;
      nc_q     <= nc_d;
      cw_q     <= cw_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      hold_v_q <= hold_v_d;
      nout_q   <= nout_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    pend_q <= pend_d;
    slot_q <= slot_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign sts_o = '{
    clr_done: (clr_q == CW'(DEPTH - 1)),
    pv:       pv_q,
    last:     last_q,
    hit:      rd_q.v && (rd_q.prefix == prefix_q) && (rd_q.data == byte_q),
    empty:    !rd_q.v,
    ge8:      (cnt_q >= CNTW'(ByteW)),
    nz:       (cnt_q != '0),
    can_put:  !room || !hold_v_q || out_free,
    hold_v:   hold_v_q,
    out_free: out_free
  };

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

endmodule

// ===== design/vwc_ctrl.sv =====
module vwc_ctrl import vwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_CMP, S_APP, S_DRAIN, S_INS, S_CHK, S_FLUSH, S_FIN
  } state_e;

  state_e st_q, st_d;
  logic   ph_q, ph_d;   // 1: packing the closing code of a stream
  logic   rdy_q, rdy_d;

  always_comb begin
    cmd_o = '0;
    st_d  = st_q;
    ph_d  = ph_q;
    case (st_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.latch = 1'b1;
          ph_d = 1'b0;
          if (!sts_i.pv) begin
            cmd_o.first = 1'b1;
            st_d = S_CHK;
          end else begin
            st_d = S_RD;
          end
        end
      end
      S_RD: st_d = S_CMP;
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.set_hit = 1'b1;
          st_d = S_CHK;
        end else if (sts_i.empty) begin
          st_d = S_APP;
        end else begin
          cmd_o.probe_nxt = 1'b1;
          st_d = S_RD;
        end
      end
      S_APP: begin
        cmd_o.append = 1'b1;
        st_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts_i.ge8) begin
          if (sts_i.can_put) cmd_o.produce = 1'b1;
        end else begin
          st_d = ph_q ? S_FLUSH : S_INS;
        end
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        st_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.last) begin
          ph_d = 1'b1;
          st_d = S_APP;
        end else begin
          st_d = S_FIN;
        end
      end
      S_FLUSH: begin
        if (!sts_i.nz) begin
          st_d = S_FIN;
        end else if (sts_i.can_put) begin
          cmd_o.flush = 1'b1;
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.hold_v || sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          if (sts_i.last) begin
            cmd_o.init = 1'b1;
            st_d = S_CLR;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_CLR;
    endcase
    rdy_d = (st_d == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      ph_q  <= 1'b0;
      rdy_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      rdy_q <= rdy_d;
    end
  end

  assign in_ready_o = rdy_q;

  a_rdy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> st_q == S_IDLE) else $error("ready outside idle");
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && rdy_q) |=> !rdy_q) else $error("second request taken at once");
  a_clr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLR && sts_i.clr_done) |=> st_q == S_IDLE)
    else $error("clearing pass did not end");

endmodule

// ===== tb/lzw_compressor_variable_width_unit_test.sv =====
module lzw_compressor_variable_width_unit_test import vwc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DictSize = 4096;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  out_req_t out_req_o;

  lzw_compressor_variable_width_unit #(.DICT_SIZE(DictSize)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_req_o
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the compressor's dictionary and packer.
  // ---------------------------------------------------------------------------
  logic [12:0] dict_pfx [DictSize];
  logic [7:0]  dict_chr [DictSize];
  bit          dict_ok  [DictSize];
  logic [12:0] cur_str;
  bit          str_open;
  int unsigned next_entry;
  int unsigned code_bits;
  logic [7:0]  pack_acc;
  int unsigned pack_cnt;

  out_req_t expected_bytes[$];  // packed bytes still to come out of the block
  in_req_t  pending_reqs[$];    // input requests not yet offered
  int unsigned errors;
  int unsigned bytes_checked;
  int unsigned streams_sent;
  bit          in_taken;        // input request accepted at the last rising edge

  function automatic void clear_dict();
    for (int i = 0; i < DictSize; i++) dict_ok[i] = 1'b0;
    cur_str    = '0;
    str_open   = 1'b0;
    next_entry = FirstNew;
    code_bits  = InitCw;
    pack_acc   = '0;
    pack_cnt   = 0;
  endfunction

  // Emit one packed byte; per-request cap matches the block's output limit.
  function automatic void push_byte(logic [7:0] b, ref int unsigned n);
    out_req_t r;
    if (n < MaxOut) begin
      r.out_byte = b;
      r.out_last = 1'b0;
      expected_bytes = {expected_bytes, r};
      n++;
    end
  endfunction

  function automatic void pack_code(logic [12:0] code, ref int unsigned n);
    for (int i = int'(code_bits); i > 0; i--) begin
      pack_acc = {pack_acc[6:0], code[i-1]};
      pack_cnt++;
      if (pack_cnt == 8) begin
        push_byte(pack_acc, n);
        pack_acc = '0;
        pack_cnt = 0;
      end
    end
  endfunction

  function automatic void compress_byte(in_req_t r);
    int unsigned n;
    bit          hit;
    int unsigned hit_code;
    n = 0;
    hit = 1'b0;
    hit_code = 0;
    if (!str_open) begin
      cur_str  = {5'd0, r.in_byte};
      str_open = 1'b1;
    end else begin
      for (int c = FirstNew; c < int'(next_entry) && c < DictSize; c++) begin
        if (!hit && dict_ok[c] && dict_pfx[c] == cur_str && dict_chr[c] == r.in_byte) begin
          hit = 1'b1;
          hit_code = c;
        end
      end
      if (hit) begin
        cur_str = hit_code[12:0];
      end else begin
        pack_code(cur_str, n);
        if (next_entry < DictSize) begin
          dict_pfx[next_entry] = cur_str;
          dict_chr[next_entry] = r.in_byte;
          dict_ok[next_entry]  = 1'b1;
          next_entry++;
          if (next_entry > (1 << code_bits)) code_bits++;
        end
        cur_str = {5'd0, r.in_byte};
      end
    end
    if (r.in_last) begin
      pack_code(cur_str, n);
      if (pack_cnt > 0) push_byte(pack_acc << (8 - pack_cnt), n);
      if (n > 0) begin
        expected_bytes[expected_bytes.size() - 1].out_last = 1'b1;
      end
      clear_dict();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shaping: idle rates per phase, plus one long receiver hold-off.
  // ---------------------------------------------------------------------------
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off;

  // Driver: offers the next queued request; valid stays up until accepted.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compares each accepted byte with the oldest expectation, then
  // runs the predictor on an input request accepted at the same edge.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h last %b", $time,
                 out_req_o.out_byte, out_req_o.out_last);
        errors++;
      end else begin
        out_req_t exp_r;
        exp_r = expected_bytes.pop_front();
        bytes_checked++;
        if (exp_r.out_byte !== out_req_o.out_byte)
          begin
          $display("%0t: out_byte expected %h actual %h", $time,
                   exp_r.out_byte, out_req_o.out_byte);
          errors++;
        end
        if (exp_r.out_last !== out_req_o.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time,
                   exp_r.out_last, out_req_o.out_last);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) compress_byte(in_req_i);
  end

  // Stream builder: a small alphabet gives repetitive text that grows deep dictionary chains; 256 gives random bytes.
  function automatic void queue_stream(int unsigned len, int unsigned alpha);
    in_req_t r;
    for (int i = 0; i < int'(len); i++) begin
      r.in_byte = (alpha >= 256) ? 8'($urandom_range(255))
                                 : 8'($urandom_range(alpha - 1) + 8'h61);
      r.in_last = (i == int'(len) - 1);
      pending_reqs = {pending_reqs, r};
    end
    streams_sent++;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    in_req_t r;
    errors = 0;
    bytes_checked = 0;
    streams_sent = 0;
    in_taken = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 70;
    clear_dict();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: lone bytes at the extremes, a repeat run, all-ones and zeros.
    r = '{in_byte: 8'h00, in_last: 1'b1}; pending_reqs = {pending_reqs, r};
    r = '{in_byte: 8'hFF, in_last: 1'b1}; pending_reqs = {pending_reqs, r};
    for (int i = 0; i < 12; i++) begin
      r = '{in_byte: 8'hAA, in_last: (i == 11)}; pending_reqs = {pending_reqs, r};
    end
    for (int i = 0; i < 8; i++) begin
      r = '{in_byte: (i[0] ? 8'hFF : 8'h00), in_last: (i == 7)};
      pending_reqs = {pending_reqs, r};
    end
    streams_sent += 4;
    wait_drained();

    // Random phase 1: sender rarely idles, receiver mostly stalls.
    while (pending_reqs.size() < 100) queue_stream($urandom_range(3, 30), $urandom_range(2, 6));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering bytes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_stream(40, 256);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    wait (!hold_off);
    wait_drained();

    // Random phase 2: roles swapped.
    send_idle_pct = 70;
    recv_idle_pct = 8;
    while (pending_reqs.size() < 80) queue_stream($urandom_range(1, 25), $urandom_range(1, 256));
    wait_drained();

    // Random phase 3: full rate; one long stream grows the code width to 9.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_stream(70, 256);
    wait_drained();

    while (expected_bytes.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Compressed %0d streams; %0d output bytes checked.", streams_sent, bytes_checked);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Each stream ends in a clearing pass over all 4096 table slots; the timeout leaves ample room for them.
  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
design/vwc_pkg.sv
design/vwc_dp.sv
design/vwc_ctrl.sv
design/lzw_compressor_variable_width_unit.sv
tb/lzw_compressor_variable_width_unit_test.sv
